### sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants for the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PAGES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

    // flag bit positions within a page entry
    localparam int FLAG_TAKEN = 0;
    localparam int FLAG_LAST  = 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] block_address;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
    } t_res;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [1:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

### sv/ffpa_mem.sv
// ----------------------------------------------------------------------------
// ffpa_mem
// Page flag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffpa_mem (
    input  logic              i_clk,
    input  ffpa_pkg::t_mem_req i_req,
    output logic [1:0]        o_rd_data
);
    import ffpa_pkg::*;

    logic [1:0] r_mem [MAX_PAGES];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer: clearing pass, first-fit scan, mark walk and free walk over the
// flag store, one page per cycle.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ffpa_pkg::t_item               i_in_data,
    input  logic [ffpa_pkg::CNT_W-1:0]    i_live_pages,
    input  logic [ffpa_pkg::ADDR_W-1:0]   i_pool_base,
    input  logic                          i_out_free,
    output logic                          o_done,
    output ffpa_pkg::t_res                o_res,
    output ffpa_pkg::t_mem_req            o_mem_req,
    input  logic [1:0]                    i_rd_data
);
    import ffpa_pkg::*;

    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_A_CHK  = 8'b0000_0100,
        S_A_SCAN = 8'b0000_1000,
        S_A_MARK = 8'b0001_0000,
        S_F_CHK  = 8'b0010_0000,
        S_F_WALK = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    t_item            r_item, n_item;
    t_res             r_res, n_res;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_start, n_start;
    logic [CNT_W-1:0] r_run, n_run;
    logic [CNT_W-1:0] r_left, n_left;

    logic [CNT_W-1:0]  n_m1;
    logic              ptr_last;
    logic              taken;
    logic              last;
    logic [CNT_W-1:0]  run_nx;
    logic [CNT_W-1:0]  start_c;
    logic [ADDR_W:0]   pool_end;
    logic [ADDR_W-1:0] offset;
    logic              free_bad;

    assign n_m1     = i_live_pages - CNT_W'(1);
    assign ptr_last = (CNT_W'(r_ptr) == n_m1);
    assign taken    = i_rd_data[FLAG_TAKEN];
    assign last     = i_rd_data[FLAG_LAST];
    assign run_nx   = taken ? '0 : r_run + CNT_W'(1);
    assign start_c  = CNT_W'(r_ptr) + CNT_W'(1) - r_item.page_count;

    // end of pool computed without wrap
    assign pool_end = {1'b0, i_pool_base}
                    + ((ADDR_W+1)'(i_live_pages) << PAGE_SHIFT);
    assign offset   = r_item.block_address - i_pool_base;
    assign free_bad = (r_item.block_address == '0)
                   || (r_item.block_address < i_pool_base)
                   || ({1'b0, r_item.block_address} >= pool_end);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_res     = r_res;
        n_ptr     = r_ptr;
        n_start   = r_start;
        n_run     = r_run;
        n_left    = r_left;
        o_mem_req = '0;

        unique case (r_state)
            S_CLR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_ptr;
                o_mem_req.wdata = 2'b00;
                n_ptr           = r_ptr + IDX_W'(1);
                if (r_ptr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = (i_in_data.kind == KIND_ALLOC) ? S_A_CHK : S_F_CHK;
                end
            end
            S_A_CHK: begin
                n_res.address = '0;
                n_res.status  = ST_NOSPACE;
                if (r_item.page_count == '0 || r_item.page_count > i_live_pages) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = '0;
                    n_ptr           = '0;
                    n_run           = '0;
                    n_state         = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                n_run = run_nx;
                if (!taken && run_nx == r_item.page_count) begin
                    n_ptr   = start_c[IDX_W-1:0];
                    n_start = start_c[IDX_W-1:0];
                    n_left  = r_item.page_count;
                    n_state = S_A_MARK;
                end else if (ptr_last) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_ptr + IDX_W'(1);
                    n_ptr           = r_ptr + IDX_W'(1);
                end
            end
            S_A_MARK: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_ptr;
                o_mem_req.wdata = {(r_left == CNT_W'(1)), 1'b1};
                n_ptr           = r_ptr + IDX_W'(1);
                n_left          = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_res.address = i_pool_base + (ADDR_W'(r_start) << PAGE_SHIFT);
                    n_res.status  = ST_DONE;
                    n_state       = S_DONE;
                end
            end
            S_F_CHK: begin
                n_res.address = '0;
                if (free_bad) begin
                    n_res.status = ST_IGNORED;
                    n_state      = S_DONE;
                end else begin
                    n_res.status    = ST_DONE;
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = offset[PAGE_SHIFT +: IDX_W];
                    n_ptr           = offset[PAGE_SHIFT +: IDX_W];
                    n_state         = S_F_WALK;
                end
            end
            S_F_WALK: begin
                if (!taken) begin
                    n_state = S_DONE;
                end else begin
                    // clear this page, fetch the next one in the same cycle
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_ptr;
                    o_mem_req.wdata = 2'b00;
                    if (last || ptr_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = r_ptr + IDX_W'(1);
                        n_ptr           = r_ptr + IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
        r_item  <= n_item;
        r_res   <= n_res;
        r_start <= n_start;
        r_run   <= n_run;
        r_left  <= n_left;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_done     = (r_state == S_DONE);
    assign o_res      = r_res;

endmodule

### sv/first_fit_page_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top
// Steps per item: alloc runs a check, the first-fit scan and a mark walk (none
// marked on failure); free runs a check and the walk that clears its pages.
// Throughput: one item at a time, at most one flag store read and one write per cycle.
// Result is held in an output register. Reset: registers default (1024 pages,
// base 0); a clearing pass then zeroes the flag store, with input stalled
// until it ends.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ffpa_pkg::t_item             i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ffpa_pkg::t_res              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ffpa_pkg::*;

    localparam logic REG_PAGES = 1'b0;
    localparam logic REG_BASE  = 1'b1;

    logic [CNT_W-1:0]  r_pages_in_use;
    logic [ADDR_W-1:0] r_pool_base;
    logic              r_out_valid;
    t_res              r_out_data;

    logic [CNT_W-1:0] live_pages;
    logic             cfg_wr;
    logic             out_free;
    logic             done;
    t_res             res;
    t_mem_req         mem_req;
    logic [1:0]       rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= MAX_CNT;
            r_pool_base    <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PAGES) begin
                r_pages_in_use <= pwdata[CNT_W-1:0];
            end else begin
                r_pool_base <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_BASE) ? r_pool_base : 32'(r_pages_in_use);

    assign live_pages = (r_pages_in_use > MAX_CNT) ? MAX_CNT : r_pages_in_use;

    // output register: a finished beat waits here while the next item runs
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done;
        end
        if (out_free && done) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ffpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_live_pages (live_pages),
        .i_pool_base  (r_pool_base),
        .i_out_free   (out_free),
        .o_done       (done),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_rd_data    (rd_data)
    );

    ffpa_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule
